/* src/rspe_pkg.sv */
// Package: types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
package rspe_pkg;

   localparam int PARITY_COUNT = 30;
   localparam int CNT_W        = $clog2(PARITY_COUNT + 1);
   localparam logic [8:0] GF_POLY  = 9'h11D;
   localparam logic [7:0] GF_ALPHA = 8'h02;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [7:0] parity_byte;
      logic       parity_last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic load;
      logic pop;
   } cell_ctrl_type;

   typedef logic [PARITY_COUNT-1:0][7:0] gen_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] a;
      logic [7:0] acc;
      acc = 8'h00;
      a   = {1'b0, x};
      for (int k = 0; k < 8; k++) begin
         if (y[k]) acc = acc ^ a[7:0];
         a = {a[7:0], 1'b0};
         if (a[8]) a = a ^ GF_POLY;
      end
      return acc;
   endfunction

   // index 0 holds the coefficient of x^(PARITY_COUNT-1)
   function automatic gen_type build_gen();
      gen_type    g;
      logic [7:0] root;
      logic [7:0] t;
      g = '0;
      g[PARITY_COUNT-1] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < PARITY_COUNT; i++) begin
         for (int j = 0; j < PARITY_COUNT; j++) begin
            t = gf_mul(g[j], root);
            if (j + 1 < PARITY_COUNT) t = t ^ g[j+1];
            g[j] = t;
         end
         root = gf_mul(root, GF_ALPHA);
      end
      return g;
   endfunction

   localparam gen_type GEN_COEF = build_gen();

endpackage

/* src/rspe_cell.sv */
// One remainder cell: remainder byte with constant GF multiply-add, plus parity unload byte.
module rspe_cell
   import rspe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    coef,
   input  logic [7:0]    fb,
   input  logic [7:0]    rem_next,
   input  logic [7:0]    out_next,
   output logic [7:0]    rem_q,
   output logic [7:0]    out_q
);

   logic [7:0] rem_ff;
   logic [7:0] rem_in;
   logic [7:0] out_ff;

   assign rem_in = rem_next ^ gf_mul(coef, fb);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 8'h00;
      end else if (ctrl.accept) begin
         rem_ff <= ctrl.clear ? 8'h00 : rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         out_ff <= rem_in;
      end else if (ctrl.pop) begin
         out_ff <= out_next;
      end
   end

   assign rem_q = rem_ff;
   assign out_q = out_ff;

endmodule

/* src/reed_solomon_parity_encoder_top.sv */
// Top level: Reed-Solomon GF(256) parity encoder built from a chain of remainder cells.
// Takes one data byte per cycle; a byte without block_end is never stalled.
// Parity of a block starts in the cycle after its last byte is accepted; the cell unload
// chain streams PARITY_COUNT bytes, highest order first, one per cycle unless stalled.
// A block-end byte stalls while an earlier block's parity is still unloading.
// Synchronous reset clears the remainder cells and empties the parity output.
module reed_solomon_parity_encoder_top
   import rspe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0]       rem_q [PARITY_COUNT];
   logic [7:0]       out_q [PARITY_COUNT];
   logic [7:0]       fb;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             req_take;
   logic             rsp_take;
   logic             final_take;
   cell_ctrl_type    ctrl;

   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign final_take = rsp_take && (cnt_ff == CNT_W'(1));
   assign req_stall  = req_data.block_end && rsp_valid && !final_take;
   assign req_take   = req_valid && !req_stall;
   assign fb         = req_data.data_byte ^ rem_q[0];

   always_comb begin
      ctrl.accept = req_take;
      ctrl.clear  = req_data.block_end;
      ctrl.load   = req_take && req_data.block_end;
      ctrl.pop    = rsp_take;
   end

   for (genvar i = 0; i < PARITY_COUNT; i++) begin : g_cell
      logic [7:0] rem_next;
      logic [7:0] out_next;
      if (i == PARITY_COUNT - 1) begin : g_tail
         assign rem_next = 8'h00;
         assign out_next = 8'h00;
      end else begin : g_body
         assign rem_next = rem_q[i+1];
         assign out_next = out_q[i+1];
      end
      rspe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .coef     (GEN_COEF[i]),
         .fb       (fb),
         .rem_next (rem_next),
         .out_next (out_next),
         .rem_q    (rem_q[i]),
         .out_q    (out_q[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         cnt_in = CNT_W'(PARITY_COUNT);
      end else if (rsp_take) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_data.parity_byte = out_q[0];
   assign rsp_data.parity_last = (cnt_ff == CNT_W'(1));

   a_load_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (cnt_ff == CNT_W'(PARITY_COUNT)))
      else $error("parity burst not loaded after block end");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> (!rsp_valid || final_take))
      else $error("block end accepted while parity still unloading");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_data.parity_last && !ctrl.load) |=> !rsp_valid)
      else $error("output valid after final parity byte");

endmodule
